// ----- sv/wrr_sched_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted round-robin scheduler package
// Shared widths, event codes, slot state codes and status codes.
// ----------------------------------------------------------------------------
package wrr_sched_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int FUNC_W        = 4;
  localparam int SLOT_FIELD_W  = 3;
  localparam int PRIO_W        = 8;
  localparam int MS_W          = 32;
  localparam int STATUS_W      = 2;
  localparam int CFG_W         = 32;
  localparam int BIT_CNT_W     = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_STEP     = 4'd0,
    FN_START    = 4'd1,
    FN_DELAY    = 4'd2,
    FN_PAUSE    = 4'd3,
    FN_RESUME   = 4'd4,
    FN_KILL     = 4'd5,
    FN_EXIT     = 4'd6,
    FN_SET_PRIO = 4'd7,
    FN_TICK     = 4'd8
  } func_t;

  typedef enum logic [2:0] {
    SS_FREE    = 3'd0,
    SS_INIT    = 3'd1,
    SS_READY   = 3'd2,
    SS_PAUSED  = 3'd3,
    SS_WAITING = 3'd4,
    SS_LOCKED  = 3'd5,
    SS_EXITED  = 3'd6
  } slot_state_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_SLOT  = 2'd1,
    STAT_SELF_KILL = 2'd2,
    STAT_NO_TASKS  = 2'd3
  } status_t;

  function automatic logic is_listed_st(slot_state_t s);
    return (s == SS_INIT) || (s == SS_READY) || (s == SS_PAUSED) ||
           (s == SS_WAITING) || (s == SS_LOCKED);
  endfunction

  function automatic logic is_running_st(slot_state_t s);
    return (s == SS_INIT) || (s == SS_READY) || (s == SS_WAITING) ||
           (s == SS_LOCKED);
  endfunction

endpackage

// ----- sv/wrr_sched_if.sv -----
// ----------------------------------------------------------------------------
// Weighted round-robin scheduler channels
// Event channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wrr_sched_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [wrr_sched_pkg::FUNC_W-1:0]        func;
  logic [wrr_sched_pkg::SLOT_FIELD_W-1:0]  task_slot;
  logic [wrr_sched_pkg::PRIO_W-1:0]        priority_req;
  logic [wrr_sched_pkg::MS_W-1:0]          wait_ms;

  modport source (output valid, func, task_slot, priority_req, wait_ms, input ready);
  modport sink (input valid, func, task_slot, priority_req, wait_ms, output ready);
endinterface

interface wrr_sched_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    dispatch;
  logic [wrr_sched_pkg::SLOT_FIELD_W-1:0]  task_id;
  logic                                    first_run;
  logic [wrr_sched_pkg::STATUS_W-1:0]      status;
  logic                                    running;
  logic                                    sleep_request;

  modport source (output valid, dispatch, task_id, first_run, status, running,
                  sleep_request, input ready);
  modport sink (input valid, dispatch, task_id, first_run, status, running,
                sleep_request, output ready);
endinterface

// ----- sv/weighted_round_robin_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// Weighted round-robin task scheduler
// Slot table, ring search, wait counters and sleep request generation.
// ----------------------------------------------------------------------------
// Events arrive on in_ch (step, start, delay, pause, resume, kill, exit,
// set priority, tick) and each event produces exactly one result item on
// out_ch in the cycle after it is accepted. The whole event is evaluated
// combinationally against the slot registers, so one event per cycle is
// sustained while out_ch keeps up and no sleep phase realignment is running.
// cfg_we/cfg_wdata write the sleep interval. After each write the sleep
// phase is realigned by a bit-serial remainder unit over the step count
// (which is not started when the interval is zero); in_ch.ready is low while it runs.
// Reset clears all slots to free, priorities and waits to zero, the ring
// position, run count, step count and the sleep interval.
// The result register holds its item while out_ch.ready is low; a new event
// is accepted in the same cycle that the held item is taken, so a stalled
// receiver stalls the event channel and nothing is dropped.
// ----------------------------------------------------------------------------
module weighted_round_robin_task_scheduler #(
  parameter int MAX_TASKS = wrr_sched_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wrr_sched_in_if.sink                     in_ch,
  wrr_sched_out_if.source                  out_ch,
  input  logic                             cfg_we,
  input  logic [wrr_sched_pkg::CFG_W-1:0]  cfg_wdata
);
  import wrr_sched_pkg::*;

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  typedef logic [SLOT_W-1:0] slot_idx_t;

  slot_state_t        st_r   [MAX_TASKS];
  slot_state_t        st_nxt [MAX_TASKS];
  logic [PRIO_W-1:0]  prio_r   [MAX_TASKS];
  logic [PRIO_W-1:0]  prio_nxt [MAX_TASKS];
  logic [MS_W-1:0]    wait_r   [MAX_TASKS];
  logic [MS_W-1:0]    wait_nxt [MAX_TASKS];
  slot_idx_t          cur_r, cur_nxt;
  logic [PRIO_W-1:0]  rc_r, rc_nxt;
  logic [31:0]        step_cnt_r, step_cnt_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [CFG_W-1:0]   rem_r, rem_step;
  logic               busy_r;
  logic [BIT_CNT_W-1:0] bit_r;

  logic               out_valid_r;
  logic               out_dispatch_r, out_dispatch_nxt;
  logic [SLOT_FIELD_W-1:0] out_task_id_r, out_task_id_nxt;
  logic               out_first_r, out_first_nxt;
  status_t            out_status_r, out_status_nxt;
  logic               out_running_r, out_running_nxt;
  logic               out_sleep_r, out_sleep_nxt;

  logic [MAX_TASKS-1:0] listed, listed_ex;
  logic               in_acc;
  logic [31:0]        slot_wide, tid_wide, step_inc;
  logic               slot_ok, any_l, slot_l, cur_l;
  slot_idx_t          sidx, nl_cur, cur1, nl_cur1, nl_exit, tid;
  logic [PRIO_W-1:0]  rc1, rc_c;
  slot_state_t        st_c;
  logic [CFG_W:0]     rem_inc, mod_t, mod_sub;

  function automatic slot_idx_t next_listed(logic [MAX_TASKS-1:0] lst, slot_idx_t cur);
    slot_idx_t res;
    slot_idx_t lo_idx;
    logic      hi;
    logic      lo;
    res    = cur;
    lo_idx = cur;
    hi     = 1'b0;
    lo     = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (lst[i] && !lo) begin
        lo     = 1'b1;
        lo_idx = SLOT_W'(i);
      end
      if (lst[i] && !hi && (i > int'(cur))) begin
        hi  = 1'b1;
        res = SLOT_W'(i);
      end
    end
    if (!hi) begin
      res = lo_idx;
    end
    return res;
  endfunction

  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      listed[i]    = is_listed_st(st_r[i]);
      listed_ex[i] = listed[i] && (SLOT_W'(i) != cur_r);
    end
  end

  assign slot_wide = 32'(in_ch.task_slot);
  assign slot_ok   = slot_wide < 32'(MAX_TASKS);
  assign sidx      = slot_wide[SLOT_W-1:0];
  assign any_l     = |listed;
  assign slot_l    = slot_ok && listed[sidx];
  assign cur_l     = listed[cur_r];
  assign nl_cur    = next_listed(listed, cur_r);
  assign cur1      = cur_l ? cur_r : nl_cur;
  assign rc1       = cur_l ? rc_r : '0;
  assign nl_cur1   = next_listed(listed, cur1);
  assign nl_exit   = next_listed(listed_ex, cur_r);

  assign step_inc  = step_cnt_r + 32'd1;
  assign rem_inc   = {1'b0, rem_r} + (CFG_W+1)'(1);
  assign rem_step  = ((step_inc == 32'd0) || (rem_inc == {1'b0, cfg_r})) ? '0
                                                                         : rem_inc[CFG_W-1:0];

  always_comb begin
    st_nxt           = st_r;
    prio_nxt         = prio_r;
    wait_nxt         = wait_r;
    cur_nxt          = cur_r;
    rc_nxt           = rc_r;
    step_cnt_nxt     = step_cnt_r;
    out_dispatch_nxt = 1'b0;
    out_first_nxt    = 1'b0;
    out_status_nxt   = STAT_OK;
    out_sleep_nxt    = 1'b0;
    tid              = cur_r;
    st_c             = st_r[cur1];
    rc_c             = rc1;
    case (func_t'(in_ch.func))
      FN_STEP: begin
        step_cnt_nxt  = step_inc;
        out_sleep_nxt = (cfg_r != '0) && (rem_step == '0);
        if (!any_l) begin
          out_status_nxt = STAT_NO_TASKS;
          tid            = cur_r;
        end else begin
          cur_nxt = cur1;
          rc_nxt  = rc1;
          if (st_r[cur1] == SS_INIT) begin
            st_nxt[cur1]     = SS_READY;
            out_dispatch_nxt = 1'b1;
            out_first_nxt    = 1'b1;
            cur_nxt          = nl_cur1;
          end else begin
            if ((st_c == SS_WAITING) && (wait_r[cur1] == '0)) begin
              st_c = SS_READY;
            end
            st_nxt[cur1] = st_c;
            if (st_c == SS_READY) begin
              out_dispatch_nxt = 1'b1;
              if (rc1 != '1) begin
                rc_c = rc1 + PRIO_W'(1);
              end
            end
            rc_nxt = rc_c;
            if (rc_c >= prio_r[cur1]) begin
              cur_nxt = nl_cur1;
              rc_nxt  = '0;
            end
          end
          tid = cur1;
        end
      end
      FN_START: begin
        if (!slot_ok || ((st_r[sidx] != SS_FREE) && (st_r[sidx] != SS_EXITED))) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else begin
          if (!any_l) begin
            cur_nxt = sidx;
            rc_nxt  = '0;
          end
          st_nxt[sidx]   = SS_INIT;
          prio_nxt[sidx] = in_ch.priority_req;
          wait_nxt[sidx] = '0;
        end
        tid = cur_nxt;
      end
      FN_DELAY: begin
        if (!any_l) begin
          out_status_nxt = STAT_NO_TASKS;
        end else if (!cur_l) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else begin
          wait_nxt[cur_r] = in_ch.wait_ms;
          st_nxt[cur_r]   = SS_WAITING;
        end
        tid = cur_r;
      end
      FN_EXIT: begin
        if (!any_l) begin
          out_status_nxt = STAT_NO_TASKS;
        end else if (!cur_l) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else begin
          st_nxt[cur_r] = SS_EXITED;
          cur_nxt       = nl_exit;
          rc_nxt        = '0;
        end
        tid = cur_nxt;
      end
      FN_PAUSE, FN_RESUME: begin
        if (!slot_l) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else begin
          st_nxt[sidx] = (func_t'(in_ch.func) == FN_PAUSE) ? SS_PAUSED : SS_READY;
        end
        tid = cur_r;
      end
      FN_KILL: begin
        if (!any_l) begin
          out_status_nxt = STAT_NO_TASKS;
        end else if (!slot_l) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else if (slot_wide == 32'(cur_r)) begin
          out_status_nxt = STAT_SELF_KILL;
        end else begin
          st_nxt[sidx] = SS_EXITED;
        end
        tid = cur_r;
      end
      FN_SET_PRIO: begin
        if (!slot_ok) begin
          out_status_nxt = STAT_BAD_SLOT;
        end else begin
          prio_nxt[sidx] = in_ch.priority_req;
        end
        tid = cur_r;
      end
      FN_TICK: begin
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (wait_r[i] != '0) begin
            wait_nxt[i] = wait_r[i] - MS_W'(1);
          end
        end
        tid = cur_r;
      end
      default: begin
        tid = cur_r;
      end
    endcase
    tid_wide        = 32'(tid);
    out_task_id_nxt = tid_wide[SLOT_FIELD_W-1:0];
    out_running_nxt = slot_ok && is_running_st(st_nxt[sidx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        st_r[i]   <= SS_FREE;
        prio_r[i] <= '0;
        wait_r[i] <= '0;
      end
      cur_r      <= '0;
      rc_r       <= '0;
      step_cnt_r <= '0;
    end else if (in_acc) begin
      st_r       <= st_nxt;
      prio_r     <= prio_nxt;
      wait_r     <= wait_nxt;
      cur_r      <= cur_nxt;
      rc_r       <= rc_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  assign mod_t   = {rem_r, step_cnt_r[bit_r]};
  assign mod_sub = mod_t - {1'b0, cfg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '0;
      rem_r  <= '0;
      busy_r <= 1'b0;
      bit_r  <= '0;
    end else if (cfg_we) begin
      cfg_r  <= cfg_wdata;
      rem_r  <= '0;
      busy_r <= (cfg_wdata != '0);
      bit_r  <= '1;
    end else if (busy_r) begin
      rem_r  <= (mod_t >= {1'b0, cfg_r}) ? mod_sub[CFG_W-1:0] : mod_t[CFG_W-1:0];
      bit_r  <= bit_r - BIT_CNT_W'(1);
      busy_r <= (bit_r != '0);
    end else if (in_acc && (func_t'(in_ch.func) == FN_STEP)) begin
      rem_r <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_dispatch_r <= out_dispatch_nxt;
      out_task_id_r  <= out_task_id_nxt;
      out_first_r    <= out_first_nxt;
      out_status_r   <= out_status_nxt;
      out_running_r  <= out_running_nxt;
      out_sleep_r    <= out_sleep_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.dispatch      = out_dispatch_r;
  assign out_ch.task_id       = out_task_id_r;
  assign out_ch.first_run     = out_first_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.running       = out_running_r;
  assign out_ch.sleep_request = out_sleep_r;

  a_busy_blocks_events: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ch.ready)
    else $error("event accepted while the sleep phase is being realigned");

  a_result_follows_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_r) < 32'(MAX_TASKS))
    else $error("current slot outside the slot table");

  a_rem_below_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && (cfg_r != '0)) |-> (rem_r < cfg_r))
    else $error("sleep phase not below the sleep interval");

  a_dispatch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dispatch_r) |-> (out_status_r == STAT_OK))
    else $error("dispatch reported with an error status");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Weighted round-robin task scheduler testbench
// Sends scheduler events through the event channel and predicts each result
// with a cycle-free model of the slot table, ring position, run count and
// sleep interval. The result channel is checked item by item against the
// predictions. Directed tests cover the empty ring, ring order, waits, kills
// and the sleep interval; random phases with bursty input and a stalling
// receiver follow, plus one long pass at the largest weights.
// ----------------------------------------------------------------------------
module tb;
  import wrr_sched_pkg::*;

  localparam int SLOTS = MAX_TASKS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_REPORTS = 10;
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 4'd9;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic                    dispatch;
    logic [SLOT_FIELD_W-1:0] task_id;
    logic                    first_run;
    status_t                 status;
    logic                    running;
    logic                    sleep_req;
  } sched_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  wrr_sched_in_if  in_if ();
  wrr_sched_out_if out_if ();

  weighted_round_robin_task_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  slot_state_t             slot_st [SLOTS];
  logic [PRIO_W-1:0]       slot_prio [SLOTS];
  logic [MS_W-1:0]         slot_wait [SLOTS];
  logic [SLOT_FIELD_W-1:0] cur_slot;
  logic [PRIO_W-1:0]       runs;
  logic [31:0]             steps;
  logic [CFG_W-1:0]        sleep_period;

  sched_result_t pending_results [$];

  int  cycle_cnt;
  int  events_sent;
  int  results_checked;
  int  dispatch_seen;
  int  sleep_seen;
  int  mismatches;
  int  burst_left;
  bit  tx_gaps;
  bit  rx_stalls;
  logic [7:0] stall_phase;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt,
               pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // When rx_stalls is set, the receiver stalls on a fixed beat plus random drops
  // and a long periodic stall while stall_phase[6:4] is 5.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    if (!rx_stalls) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= (stall_phase % 5 != 0) && ($urandom_range(0, 7) != 0) &&
                      (stall_phase[6:4] != 3'd5);
    end
  end

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.dispatch  = out_if.dispatch;
      got.task_id   = out_if.task_id;
      got.first_run = out_if.first_run;
      got.status    = status_t'(out_if.status);
      got.running   = out_if.running;
      got.sleep_req = out_if.sleep_request;
      if (got.dispatch === 1'b1) dispatch_seen++;
      if (got.sleep_req === 1'b1) sleep_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result item at cycle %0d.", cycle_cnt);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Mismatch at cycle %0d, item %0d:", cycle_cnt, results_checked);
            $display("  expected dispatch=%0b task_id=%0d first_run=%0b status=%0d",
                     want.dispatch, want.task_id, want.first_run, want.status);
            $display("           running=%0b sleep_request=%0b", want.running,
                     want.sleep_req);
            $display("  actual   dispatch=%0b task_id=%0d first_run=%0b status=%0d",
                     got.dispatch, got.task_id, got.first_run, got.status);
            $display("           running=%0b sleep_request=%0b", got.running,
                     got.sleep_req);
          end
        end
      end
    end
  end

  function automatic bit slot_listed(int s);
    return slot_st[s] != SS_FREE && slot_st[s] != SS_EXITED;
  endfunction

  function automatic bit ring_empty();
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_listed(s)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [SLOT_FIELD_W-1:0] ring_next(int from);
    for (int k = 1; k <= SLOTS; k++) begin
      if (slot_listed((from + k) % SLOTS)) return SLOT_FIELD_W'((from + k) % SLOTS);
    end
    return SLOT_FIELD_W'(from);
  endfunction

  function automatic sched_result_t apply_event(logic [FUNC_W-1:0] fn,
                                                logic [SLOT_FIELD_W-1:0] slot,
                                                logic [PRIO_W-1:0] prio,
                                                logic [MS_W-1:0] ms);
    sched_result_t r;
    bit id_fixed;
    slot_state_t st;
    r = '0;
    r.status = STAT_OK;
    id_fixed = 1'b0;
    case (fn)
      FN_STEP: begin
        steps = steps + 32'd1;
        if (sleep_period != 0 && steps % sleep_period == 0) r.sleep_req = 1'b1;
        if (ring_empty()) begin
          r.status = STAT_NO_TASKS;
        end else begin
          if (!slot_listed(cur_slot)) begin
            cur_slot = ring_next(cur_slot);
            runs = '0;
          end
          r.task_id = cur_slot;
          id_fixed = 1'b1;
          if (slot_st[cur_slot] == SS_INIT) begin
            slot_st[cur_slot] = SS_READY;
            r.dispatch = 1'b1;
            r.first_run = 1'b1;
            cur_slot = ring_next(cur_slot);
          end else begin
            if (slot_st[cur_slot] == SS_WAITING && slot_wait[cur_slot] == 0) begin
              slot_st[cur_slot] = SS_READY;
            end
            if (slot_st[cur_slot] == SS_READY) begin
              r.dispatch = 1'b1;
              if (runs != 8'hFF) runs = runs + 8'd1;
            end
            if (runs >= slot_prio[cur_slot]) begin
              cur_slot = ring_next(cur_slot);
              runs = '0;
            end
          end
        end
      end
      FN_START: begin
        if (slot_st[slot] != SS_FREE && slot_st[slot] != SS_EXITED) begin
          r.status = STAT_BAD_SLOT;
        end else begin
          if (ring_empty()) begin
            cur_slot = slot;
            runs = '0;
          end
          slot_st[slot] = SS_INIT;
          slot_prio[slot] = prio;
          slot_wait[slot] = '0;
        end
      end
      FN_DELAY, FN_EXIT: begin
        if (ring_empty()) begin
          r.status = STAT_NO_TASKS;
        end else if (!slot_listed(cur_slot)) begin
          r.status = STAT_BAD_SLOT;
        end else if (fn == FN_DELAY) begin
          slot_wait[cur_slot] = ms;
          slot_st[cur_slot] = SS_WAITING;
        end else begin
          slot_st[cur_slot] = SS_EXITED;
          cur_slot = ring_next(cur_slot);
          runs = '0;
        end
      end
      FN_PAUSE, FN_RESUME: begin
        if (!slot_listed(slot)) begin
          r.status = STAT_BAD_SLOT;
        end else begin
          slot_st[slot] = (fn == FN_PAUSE) ? SS_PAUSED : SS_READY;
        end
      end
      FN_KILL: begin
        if (ring_empty()) begin
          r.status = STAT_NO_TASKS;
        end else if (!slot_listed(slot)) begin
          r.status = STAT_BAD_SLOT;
        end else if (slot == cur_slot) begin
          r.status = STAT_SELF_KILL;
        end else begin
          slot_st[slot] = SS_EXITED;
        end
      end
      FN_SET_PRIO: begin
        slot_prio[slot] = prio;
      end
      FN_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (slot_wait[s] != 0) slot_wait[s] = slot_wait[s] - 32'd1;
        end
      end
      default: begin
      end
    endcase
    if (!id_fixed) r.task_id = cur_slot;
    st = slot_st[slot];
    r.running = (st != SS_FREE) && (st != SS_EXITED) && (st != SS_PAUSED);
    return r;
  endfunction

  task automatic clear_model();
    for (int s = 0; s < SLOTS; s++) begin
      slot_st[s] = SS_FREE;
      slot_prio[s] = '0;
      slot_wait[s] = '0;
    end
    cur_slot = '0;
    runs = '0;
    steps = '0;
    sleep_period = '0;
  endtask

  // Called at a falling edge; returns at a falling edge with valid still high,
  // so back-to-back items keep valid asserted.
  task automatic send_event(input logic [FUNC_W-1:0] fn,
                            input logic [SLOT_FIELD_W-1:0] slot,
                            input logic [PRIO_W-1:0] prio,
                            input logic [MS_W-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      gap = (!tx_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = tx_gaps ? $urandom_range(1, 12) : 64;
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= fn;
    in_if.task_slot    <= slot;
    in_if.priority_req <= prio;
    in_if.wait_ms      <= ms;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(apply_event(fn, slot, prio, ms));
    events_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_sleep_period(input logic [CFG_W-1:0] period);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= period;
    sleep_period = period;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_ring();
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    send_event(FN_STEP, 3'd0, 8'h00, 32'h0);
    send_event(FN_DELAY, 3'd0, 8'h00, 32'hFFFF_FFFF);
    send_event(FN_EXIT, 3'd7, 8'hFF, 32'h0);
    send_event(FN_KILL, 3'd4, 8'h00, 32'h0);
    send_event(FN_PAUSE, 3'd3, 8'h00, 32'h0);
    send_event(FN_RESUME, 3'd3, 8'h00, 32'h0);
    send_event(FN_SET_PRIO, 3'd7, 8'hFF, 32'h0);
    send_event(FN_UNUSED_HI, 3'd7, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_ring_order();
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    send_event(FN_START, 3'd5, 8'd2, 32'h0);
    send_event(FN_START, 3'd0, 8'd0, 32'h0);
    send_event(FN_START, 3'd5, 8'd1, 32'h0);
    repeat (5) send_event(FN_STEP, 3'd0, 8'h00, 32'h0);
  endtask

  task automatic test_wait_and_kill();
    send_event(FN_DELAY, 3'd0, 8'h00, 32'd2);
    send_event(FN_STEP, 3'd0, 8'h00, 32'h0);
    repeat (3) send_event(FN_TICK, 3'd0, 8'h00, 32'h0);
    send_event(FN_STEP, 3'd0, 8'h00, 32'h0);
    send_event(FN_PAUSE, 3'd0, 8'h00, 32'h0);
    send_event(FN_RESUME, 3'd0, 8'h00, 32'h0);
    send_event(FN_KILL, cur_slot, 8'h00, 32'h0);
    send_event(FN_KILL, cur_slot + 3'd3, 8'h00, 32'h0);
    send_event(FN_KILL, 3'd0, 8'h00, 32'h0);
    send_event(FN_EXIT, 3'd0, 8'h00, 32'h0);
    send_event(FN_STEP, 3'd0, 8'h00, 32'h0);
  endtask

  task automatic test_sleep_interval();
    write_sleep_period(32'd1);
    send_event(FN_START, 3'd2, 8'd1, 32'h0);
    repeat (2) send_event(FN_STEP, 3'd2, 8'h00, 32'h0);
    write_sleep_period(32'hFFFF_FFFF);
    send_event(FN_STEP, 3'd2, 8'h00, 32'h0);
  endtask

  task automatic random_events(input int count);
    logic [FUNC_W-1:0]       fn;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [PRIO_W-1:0]       prio;
    logic [MS_W-1:0]         ms;
    int                      pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) fn = FN_STEP;
      else if (pick < 50) fn = FN_TICK;
      else if (pick < 62) fn = FN_START;
      else if (pick < 69) fn = FN_DELAY;
      else if (pick < 74) fn = FN_PAUSE;
      else if (pick < 81) fn = FN_RESUME;
      else if (pick < 86) fn = FN_KILL;
      else if (pick < 90) fn = FN_EXIT;
      else if (pick < 97) fn = FN_SET_PRIO;
      else fn = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
      slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      prio = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(0, 4));
      ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4);
      send_event(fn, slot, prio, ms);
    end
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] periods [5];
    periods[0] = 32'd3;
    periods[1] = 32'd0;
    periods[2] = 32'd2;
    periods[3] = 32'hFFFF_FFFF;
    periods[4] = $urandom_range(1, 9);
    for (int p = 0; p < 5; p++) begin
      write_sleep_period(periods[p]);
      tx_gaps = p[0];
      rx_stalls = p[1] | p[2];
      random_events(160);
    end
  endtask

  // Two heavy tasks on an otherwise empty ring drive the run count to its top.
  task automatic test_long_pass();
    tx_gaps = 1'b1;
    rx_stalls = 1'b0;
    while (!ring_empty()) send_event(FN_EXIT, 3'd0, 8'h00, 32'h0);
    send_event(FN_START, 3'd3, 8'hFF, 32'h0);
    send_event(FN_START, 3'd6, PRIO_W'($urandom_range(200, 255)), 32'h0);
    for (int n = 0; n < 300; n++) begin
      if ($urandom_range(0, 9) == 0) send_event(FN_TICK, 3'd0, 8'h00, $urandom);
      else send_event(FN_STEP, SLOT_FIELD_W'($urandom), 8'h00, 32'h0);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.task_slot = '0;
    in_if.priority_req = '0;
    in_if.wait_ms = '0;
    out_if.ready = 1'b0;
    stall_phase = '0;
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    burst_left = 0;
    cycle_cnt = 0;
    events_sent = 0;
    results_checked = 0;
    dispatch_seen = 0;
    sleep_seen = 0;
    mismatches = 0;
    clear_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_ring();
    test_ring_order();
    test_wait_and_kill();
    test_sleep_interval();
    test_random_phases();
    test_long_pass();
    write_sleep_period(32'd0);
    wait_until_idle();

    $display("Sent %0d events and checked %0d results in %0d cycles.", events_sent,
             results_checked, cycle_cnt);
    $display("Saw %0d dispatches and %0d sleep requests; %0d mismatches.", dispatch_seen,
             sleep_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/wrr_sched_pkg.sv
sv/wrr_sched_if.sv
sv/weighted_round_robin_task_scheduler.sv
dv/tb.sv
